// ===== rtl/mop_alu_pkg.sv =====
`timescale 1ns / 1ps

package mop_alu_pkg;

  localparam int unsigned FractionBits = 16;
  localparam int unsigned OperandBits  = 32;
  localparam int unsigned ResultBits   = 64;
  localparam int unsigned WidthBits    = 6;
  localparam int unsigned CountBits    = 7;
  localparam int unsigned DividendBits = OperandBits + FractionBits;

  // factorial of this value or more has at least 64 factors of two
  localparam logic [OperandBits-1:0] FactZeroFrom = 32'd66;

  localparam logic [WidthBits-1:0] WidthReset = 6'd4;

  localparam logic [CountBits-1:0] MulSteps = CountBits'(OperandBits);
  localparam logic [CountBits-1:0] DivSteps = CountBits'(DividendBits);

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_FACT = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]             op;
    logic [OperandBits-1:0] operand_a;
    logic [OperandBits-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [ResultBits-1:0]  full_result;
    logic [OperandBits-1:0] width_result;
    logic                   negative;
    logic                   divide_by_zero;
    logic                   above_32_bits;
    logic                   operand_too_wide;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } stat_t;

  // mask for the configured width, zero acts as one, above 32 acts as 32
  function automatic logic [OperandBits-1:0] width_mask(logic [WidthBits-1:0] w);
    logic [OperandBits-1:0] m;
    m = '1;
    if (w == '0) begin
      m = OperandBits'(1);
    end else if (w < WidthBits'(OperandBits)) begin
      m = (OperandBits'(1) << w) - OperandBits'(1);
    end
    return m;
  endfunction

endpackage

// ===== rtl/multi_op_integer_alu.sv =====
`timescale 1ns / 1ps
// an accepted transaction loads its operands, runs its steps, then registers the result and raises the result strobe
// steps: add, subtract, unknown code, divide by zero, factorial of 0, 1 or >= 66: none;
// multiply 32 (shift-and-add), divide 48 (restoring), factorial n - 1 (one 64x7 multiply each)
// one transaction in flight; the next start is taken the cycle the result strobe shows
// result stays on res_o until the next result; valid_o is high for one cycle; the receiver cannot stall it
// async active-low reset: controller idle, no strobe, operand width back to 4

module multi_op_integer_alu (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command side
  input  logic                              start,
  output logic                              busy,
  input  mop_alu_pkg::req_t                 req_i,
  // result side
  output logic                              valid_o,
  output mop_alu_pkg::res_t                 res_o,
  // operand width register
  input  logic                              cfg_we_i,
  input  logic [mop_alu_pkg::WidthBits-1:0] cfg_wdata_i
);

  // command and status between controller and datapath
  mop_alu_pkg::cmd_t  cmd;
  mop_alu_pkg::stat_t stat;

  // controller: idle until start, then steps the datapath until its count runs out
  mop_alu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // datapath: operand capture, iterative multiply / divide / factorial, result register
  mop_alu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .valid_o     (valid_o),
    .res_o       (res_o)
  );

endmodule

// ===== rtl/mop_alu_ctrl.sv =====
`timescale 1ns / 1ps

module mop_alu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mop_alu_pkg::stat_t  stat_i,
  output mop_alu_pkg::cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat_i.last) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/mop_alu_dp.sv =====
`timescale 1ns / 1ps

module mop_alu_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mop_alu_pkg::WidthBits-1:0]    cfg_wdata_i,
  input  mop_alu_pkg::req_t                    req_i,
  input  mop_alu_pkg::cmd_t                    cmd_i,
  output mop_alu_pkg::stat_t                   stat_o,
  output logic                                 valid_o,
  output mop_alu_pkg::res_t                    res_o
);

  localparam int unsigned OB = mop_alu_pkg::OperandBits;
  localparam int unsigned RB = mop_alu_pkg::ResultBits;
  localparam int unsigned CB = mop_alu_pkg::CountBits;
  localparam int unsigned DB = mop_alu_pkg::DividendBits;

  logic [mop_alu_pkg::WidthBits-1:0] width_q;
  logic [2:0]    op_q, op_d;
  logic [OB-1:0] b_q, b_d;
  logic [RB-1:0] acc_q, acc_d;
  logic [RB-1:0] shf_q, shf_d;
  logic [OB:0]   rem_q, rem_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic          neg_q, neg_d;
  logic          dz_q, dz_d;
  logic          wide_q, wide_d;
  logic          valid_q;
  mop_alu_pkg::res_t res_q, res_d;

  logic [OB-1:0] mask;
  logic [OB:0]   rem_sh;
  logic          rem_ge;
  logic [CB-1:0] fact_k;
  logic [RB+CB-1:0] fact_prod;
  logic          op_known;

  assign mask = mop_alu_pkg::width_mask(width_q);

  assign rem_sh    = {rem_q[OB-1:0], shf_q[DB-1]};
  assign rem_ge    = (rem_sh >= {1'b0, b_q});
  assign fact_k    = cnt_q + CB'(1);
  assign fact_prod = acc_q * fact_k;

  assign op_known = (req_i.op == mop_alu_pkg::OP_ADD) || (req_i.op == mop_alu_pkg::OP_SUB) ||
                    (req_i.op == mop_alu_pkg::OP_MUL) || (req_i.op == mop_alu_pkg::OP_DIV) ||
                    (req_i.op == mop_alu_pkg::OP_FACT);

  always_comb begin
    op_d   = op_q;
    b_d    = b_q;
    acc_d  = acc_q;
    shf_d  = shf_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    dz_d   = dz_q;
    wide_d = wide_q;

    if (cmd_i.load) begin
      op_d   = req_i.op;
      b_d    = req_i.operand_b;
      acc_d  = '0;
      shf_d  = '0;
      rem_d  = '0;
      cnt_d  = '0;
      neg_d  = 1'b0;
      dz_d   = 1'b0;
      wide_d = op_known && ((req_i.operand_a > mask) ||
               ((req_i.op != mop_alu_pkg::OP_FACT) && (req_i.operand_b > mask)));
      case (req_i.op)
        mop_alu_pkg::OP_ADD: begin
          acc_d = {{(RB-OB){1'b0}}, req_i.operand_a + req_i.operand_b};
        end
        mop_alu_pkg::OP_SUB: begin
          acc_d = {{(RB-OB){1'b0}}, req_i.operand_a} - {{(RB-OB){1'b0}}, req_i.operand_b};
          neg_d = (req_i.operand_a < req_i.operand_b);
        end
        mop_alu_pkg::OP_MUL: begin
          shf_d = {{(RB-OB){1'b0}}, req_i.operand_a};
          cnt_d = mop_alu_pkg::MulSteps;
        end
        mop_alu_pkg::OP_DIV: begin
          if (req_i.operand_b == '0) begin
            dz_d = 1'b1;
          end else begin
            shf_d = {{(RB-DB){1'b0}}, req_i.operand_a, {mop_alu_pkg::FractionBits{1'b0}}};
            cnt_d = mop_alu_pkg::DivSteps;
          end
        end
        mop_alu_pkg::OP_FACT: begin
          if (req_i.operand_a >= mop_alu_pkg::FactZeroFrom) begin
            acc_d = '0;
          end else begin
            acc_d = RB'(1);
            if (req_i.operand_a >= OB'(2)) begin
              cnt_d = CB'(req_i.operand_a - OB'(1));
            end
          end
        end
        default: begin
          acc_d = '0;
        end
      endcase
    end else if (cmd_i.step) begin
      cnt_d = cnt_q - CB'(1);
      case (op_q)
        mop_alu_pkg::OP_MUL: begin
          if (b_q[0]) begin
            acc_d = acc_q + shf_q;
          end
          shf_d = {shf_q[RB-2:0], 1'b0};
          b_d   = {1'b0, b_q[OB-1:1]};
        end
        mop_alu_pkg::OP_DIV: begin
          rem_d = rem_ge ? (rem_sh - {1'b0, b_q}) : rem_sh;
          shf_d = {shf_q[RB-2:0], 1'b0};
          acc_d = {acc_q[RB-2:0], rem_ge};
        end
        mop_alu_pkg::OP_FACT: begin
          // multiply by n, n-1, ... down to 2
          acc_d = fact_prod[RB-1:0];
        end
        default: begin
          cnt_d = '0;
        end
      endcase
    end
  end

  always_comb begin
    res_d                  = res_q;
    if (cmd_i.finish) begin
      res_d.full_result      = acc_q;
      res_d.width_result     = acc_q[OB-1:0] & mask;
      res_d.negative         = neg_q;
      res_d.divide_by_zero   = dz_q;
      res_d.above_32_bits    = (op_q == mop_alu_pkg::OP_FACT) && (acc_q[RB-1:OB] != '0);
      res_d.operand_too_wide = wide_q;
    end
  end

  assign stat_o.last = (cnt_q == '0);
  assign valid_o     = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= mop_alu_pkg::WidthReset;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      valid_q <= cmd_i.finish;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    shf_q  <= shf_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    dz_q   <= dz_d;
    wide_q <= wide_d;
    res_q  <= res_d;
  end

endmodule
